@@ rtl/core/sfrx_pkg.sv @@
`timescale 1ns / 1ps

package sfrx_pkg;

  // frame geometry
  localparam int FRAME_BYTES_DEF = 8;
  localparam int POS_W           = 6;
  localparam int BYTE_W          = 8;
  localparam int MS_W            = 16;

  // protocol constants
  localparam logic [BYTE_W-1:0] SYNC_BYTE     = 8'hAA;
  localparam logic [MS_W-1:0]   TIMEOUT_RESET = 16'd50;
  localparam logic [MS_W-1:0]   IDLE_MAX      = 16'hFFFF;

  // input item kinds
  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } sfrx_op_t;

  // controller states
  typedef enum logic [1:0] {
    ST_RECV = 2'd0,
    ST_READ = 2'd1,
    ST_SHOW = 2'd2
  } sfrx_state_t;

  // controller to datapath
  typedef struct packed {
    logic take;     // input item may be accepted
    logic rd_en;    // read frame store at emit index
    logic idx_clr;  // restart emit index
    logic idx_inc;  // advance emit index
    logic show;     // output item valid
  } sfrx_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_ok;  // current byte completes a frame with matching checksum
    logic idx_last;  // emit index is on the checksum byte
  } sfrx_sts_t;

endpackage

@@ rtl/core/sfrx_if.sv @@
`timescale 1ns / 1ps

// received item channel
interface sfrx_in_if
  import sfrx_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

// frame byte channel
interface sfrx_out_if
  import sfrx_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic [POS_W-1:0]  byte_position;
  logic              last_of_frame;

  modport source (output valid, output frame_byte, output byte_position,
                  output last_of_frame, input ready);
  modport sink   (input valid, input frame_byte, input byte_position,
                  input last_of_frame, output ready);
endinterface

@@ rtl/core/sfrx_ram.sv @@
`timescale 1ns / 1ps

module sfrx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/sfrx_ctrl.sv @@
`timescale 1ns / 1ps

module sfrx_ctrl
  import sfrx_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      out_ready,
  input  sfrx_sts_t sts,
  output sfrx_cmd_t cmd
);

  sfrx_state_t state;
  sfrx_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RECV;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_RECV: begin
        if (in_valid && sts.frame_ok) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_ready) state_next = sts.idx_last ? ST_RECV : ST_READ;
      end
      default: begin
        state_next = ST_RECV;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd = '0;
    case (state)
      ST_RECV: begin
        cmd.take    = 1'b1;
        cmd.idx_clr = in_valid && sts.frame_ok;
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
      end
      ST_SHOW: begin
        cmd.show    = 1'b1;
        cmd.idx_inc = out_ready && !sts.idx_last;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ rtl/core/sfrx_dp.sv @@
`timescale 1ns / 1ps

module sfrx_dp
  import sfrx_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  sfrx_cmd_t         cmd,
  output sfrx_sts_t         sts,
  input  logic              in_valid,
  input  logic              opcode,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic              cfg_wr_en,
  input  logic [MS_W-1:0]   cfg_wr_data,
  output logic [BYTE_W-1:0] frame_byte,
  output logic [POS_W-1:0]  byte_position,
  output logic              last_of_frame
);

  localparam int IDX_W = $clog2(FRAME_BYTES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_BYTES - 1);

  logic [IDX_W-1:0]  fill;
  logic [BYTE_W-1:0] running_xor;
  logic [MS_W-1:0]   idle_ms;
  logic [MS_W-1:0]   idle_ms_next;
  logic [MS_W-1:0]   idle_timeout_ms;
  logic [IDX_W-1:0]  emit_idx;

  logic fire;
  logic is_tick;
  logic skip;
  logic store;
  logic at_last;

  assign fire    = cmd.take && in_valid;
  assign is_tick = (sfrx_op_t'(opcode) == OP_TICK);
  assign at_last = (fill == LAST_IDX);
  assign skip    = (fill == '0) && (rx_byte != SYNC_BYTE);
  assign store   = fire && !is_tick && !skip;

  // saturating millisecond count
  assign idle_ms_next = (idle_ms == IDLE_MAX) ? idle_ms : idle_ms + 1'b1;

  // timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout_ms <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      idle_timeout_ms <= cfg_wr_data;
    end
  end

  // fill count, checksum and idle counter
  always_ff @(posedge clk) begin
    if (rst) begin
      fill        <= '0;
      running_xor <= '0;
      idle_ms     <= '0;
    end else if (fire) begin
      if (is_tick) begin
        idle_ms <= idle_ms_next;
        if (idle_ms_next > idle_timeout_ms) begin
          fill        <= '0;
          running_xor <= '0;
        end
      end else begin
        idle_ms <= '0;
        if (!skip) begin
          if (at_last) begin
            fill        <= '0;
            running_xor <= '0;
          end else begin
            fill        <= fill + 1'b1;
            running_xor <= running_xor ^ rx_byte;
          end
        end
      end
    end
  end

  // emit index
  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      emit_idx <= '0;
    end else if (cmd.idx_inc) begin
      emit_idx <= emit_idx + 1'b1;
    end
  end

  // frame store
  sfrx_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (FRAME_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (store),
    .waddr (fill),
    .wdata (rx_byte),
    .re    (cmd.rd_en),
    .raddr (emit_idx),
    .rdata (frame_byte)
  );

  // status and output fields
  assign sts.frame_ok  = !is_tick && !skip && at_last && (running_xor == rx_byte);
  assign sts.idx_last  = (emit_idx == LAST_IDX);
  assign byte_position = POS_W'(emit_idx);
  assign last_of_frame = sts.idx_last;

endmodule

@@ rtl/core/sync_frame_receiver_xor_check.sv @@
`timescale 1ns / 1ps

// channel   dir  handshake           payload
// rx        in   valid/ready         opcode, rx_byte
// frame     out  valid/ready         frame_byte, byte_position, last_of_frame
// cfg       in   cfg_wr_en           cfg_wr_data (idle timeout, ms)
//
// bytes and ticks are taken one per cycle while no frame is being sent
// a frame that passes its checksum is read from the store and sent byte by
// byte (store read, then output), input held off meanwhile
// a stalled output holds its byte until taken
// rst is synchronous; after it the timeout is 50 ms and no frame is open

module sync_frame_receiver_xor_check
  import sfrx_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  sfrx_in_if.sink         rx,
  sfrx_out_if.source      frame,
  input  logic            cfg_wr_en,
  input  logic [MS_W-1:0] cfg_wr_data
);

  sfrx_cmd_t cmd;
  sfrx_sts_t sts;

  // controller
  sfrx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rx.valid),
    .out_ready (frame.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  sfrx_dp #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_valid      (rx.valid),
    .opcode        (rx.opcode),
    .rx_byte       (rx.rx_byte),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .frame_byte    (frame.frame_byte),
    .byte_position (frame.byte_position),
    .last_of_frame (frame.last_of_frame)
  );

  assign rx.ready    = cmd.take;
  assign frame.valid = cmd.show;

`ifndef SYNTH
  // input is never taken while a frame is being sent
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(rx.ready && frame.valid))
    else $error("input ready while frame output active");

  // after the checksum byte leaves, input opens again
  a_reopen: assert property (@(posedge clk) disable iff (rst)
    (frame.valid && frame.ready && frame.last_of_frame) |=> rx.ready)
    else $error("input not reopened after frame end");

  // positions step by one through a frame
  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    (frame.valid && frame.ready && !frame.last_of_frame) |->
      ##2 (frame.valid &&
           frame.byte_position == POS_W'($past(frame.byte_position, 2) + 1'b1)))
    else $error("byte position did not advance by one");

  // a good frame starts at position zero
  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    (rx.valid && rx.ready && sts.frame_ok) |-> ##2 (frame.valid &&
      frame.byte_position == '0))
    else $error("frame output did not start at position zero");
`endif

endmodule

@@ dv/sync_frame_receiver_xor_check_tb.sv @@
`timescale 1ns / 1ps

module sync_frame_receiver_xor_check_tb;
  import sfrx_pkg::*;

  localparam int FRAME_LEN  = FRAME_BYTES_DEF;
  localparam int CLK_HALF   = 5;
  localparam int MAX_WAIT   = 12;
  localparam int STALL_CAP  = 2000;
  localparam int SETTLE_CYC = 4;
  localparam int TAIL_CYC   = 20;
  localparam int PRINT_CAP  = 100;
  localparam int TICK_RUN   = 20;

  typedef logic [BYTE_W-1:0] frame_body_t [FRAME_LEN-2];

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic              last;
  } frame_beat_t;

  logic            clk = 1'b0;
  logic            rst;
  logic            cfg_wr_en;
  logic [MS_W-1:0] cfg_wr_data;

  sfrx_in_if  rx_if ();
  sfrx_out_if frame_if ();

  sync_frame_receiver_xor_check DUT (
    .clk         (clk),
    .rst         (rst),
    .rx          (rx_if),
    .frame       (frame_if),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // shadow copy of the receiver state
  logic [BYTE_W-1:0] shadow_store [FRAME_LEN];
  int                shadow_fill;
  logic [BYTE_W-1:0] shadow_xor;
  logic [MS_W-1:0]   shadow_idle_ms;
  logic [MS_W-1:0]   shadow_timeout_ms;

  frame_beat_t frame_bytes_due [$];

  int mismatch_count = 0;
  int quiet_cycles   = 0;
  int sink_hold      = 0;
  bit rx_gaps        = 1'b1;
  bit sink_stalls    = 1'b1;

  always #CLK_HALF clk = ~clk;

  task automatic report_mismatch(input string what, input int want, input int got);
    if (mismatch_count < PRINT_CAP)
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
    mismatch_count++;
  endtask

  // fold one accepted item into the shadow state, queue any frame it completes
  task automatic predict_frame_bytes(input sfrx_op_t op, input logic [BYTE_W-1:0] b);
    int i;
    if (op == OP_TICK) begin
      if (shadow_idle_ms != IDLE_MAX)
        shadow_idle_ms++;
      if (shadow_fill > 0 && shadow_idle_ms > shadow_timeout_ms) begin
        shadow_fill = 0;
        shadow_xor  = '0;
      end
    end else begin
      shadow_idle_ms = '0;
      if (shadow_fill != 0 || b == SYNC_BYTE) begin
        shadow_store[shadow_fill] = b;
        if (shadow_fill + 1 < FRAME_LEN) begin
          shadow_xor ^= b;
          shadow_fill++;
        end else begin
          if (shadow_xor == b) begin
            for (i = 0; i < FRAME_LEN; i++)
              frame_bytes_due.push_back('{data: shadow_store[i], pos: POS_W'(i),
                                          last: (i == FRAME_LEN - 1)});
          end
          shadow_fill = 0;
          shadow_xor  = '0;
        end
      end
    end
  endtask

  // input side and register writes as the block sees them
  always @(posedge clk) begin
    if (rst) begin
      shadow_fill       = 0;
      shadow_xor        = '0;
      shadow_idle_ms    = '0;
      shadow_timeout_ms = TIMEOUT_RESET;
    end else begin
      if (cfg_wr_en)
        shadow_timeout_ms = cfg_wr_data;
      if (rx_if.valid && rx_if.ready)
        predict_frame_bytes(sfrx_op_t'(rx_if.opcode), rx_if.rx_byte);
    end
  end

  // compare each emitted frame byte with the oldest one due
  always @(posedge clk) begin : frame_check
    frame_beat_t want;
    if (frame_if.valid && frame_if.ready) begin
      sink_hold = sink_stalls ? $urandom_range(0, MAX_WAIT) : 0;
      if (frame_bytes_due.size() == 0) begin
        report_mismatch("frame byte with nothing due", 0, frame_if.frame_byte);
      end else begin
        want = frame_bytes_due.pop_front();
        if (frame_if.frame_byte !== want.data)
          report_mismatch("frame_byte", want.data, frame_if.frame_byte);
        if (frame_if.byte_position !== want.pos)
          report_mismatch("byte_position", want.pos, frame_if.byte_position);
        if (frame_if.last_of_frame !== want.last)
          report_mismatch("last_of_frame", want.last, frame_if.last_of_frame);
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((rx_if.valid && rx_if.ready) || (frame_if.valid && frame_if.ready) || cfg_wr_en)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_CAP) begin
      $display("%0t: no progress for %0d cycles", $realtime, STALL_CAP);
      $display("Mismatches found");
      $finish;
    end
  end

  // frame sink with random backpressure
  initial begin
    frame_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        frame_if.ready <= 1'b0;
      end else if (sink_hold > 0) begin
        frame_if.ready <= 1'b0;
        sink_hold--;
      end else begin
        frame_if.ready <= 1'b1;
      end
    end
  end

  // one item on the rx channel; starts and ends just after a falling edge
  task automatic send_item(input sfrx_op_t op, input logic [BYTE_W-1:0] b);
    int gap;
    gap = rx_gaps ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.opcode  <= op;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // sync byte, body, checksum; optional ticks between bytes
  task automatic send_frame(input frame_body_t body, input logic [BYTE_W-1:0] chk_flip,
                            input bit with_ticks, inout int sent);
    logic [BYTE_W-1:0] chk;
    chk = SYNC_BYTE;
    foreach (body[k]) chk ^= body[k];
    send_item(OP_BYTE, SYNC_BYTE);
    sent++;
    foreach (body[k]) begin
      if (with_ticks && $urandom_range(0, 3) == 0) begin
        send_item(OP_TICK, 8'($urandom_range(0, 255)));
        sent++;
      end
      send_item(OP_BYTE, body[k]);
      sent++;
    end
    send_item(OP_BYTE, chk ^ chk_flip);
    sent++;
  endtask

  // hold the sender until every due frame byte has come out
  task automatic wait_frames_drained();
    rx_if.valid <= 1'b0;
    while (frame_bytes_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  task automatic write_timeout(input logic [MS_W-1:0] value);
    wait_frames_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // skipped byte, two good frames back to back, one bad checksum
  task automatic test_sync_and_checksum();
    frame_body_t body;
    int          sent;
    sent = 0;
    send_item(OP_BYTE, 8'h00);
    body = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
    send_frame(body, 8'h00, 1'b0, sent);
    body = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_frame(body, 8'h00, 1'b0, sent);
    body = '{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06};
    send_frame(body, 8'h01, 1'b0, sent);
  endtask

  // zero timeout drops on one tick, timeout of one on the second
  task automatic test_timeout_limits();
    frame_body_t body;
    int          sent;
    sent = 0;
    body = '{8'h10, 8'h20, 8'h30, 8'h40, 8'h50, 8'h60};
    write_timeout(16'd0);
    send_item(OP_BYTE, SYNC_BYTE);
    send_item(OP_TICK, 8'h00);
    send_frame(body, 8'h00, 1'b0, sent);
    write_timeout(16'd1);
    send_item(OP_BYTE, SYNC_BYTE);
    send_item(OP_BYTE, 8'h12);
    send_item(OP_TICK, 8'hFF);
    send_item(OP_TICK, 8'h00);
    send_frame(body, 8'h00, 1'b1, sent);
  endtask

  // largest timeout keeps the open frame through a run of ticks
  task automatic test_idle_saturation();
    logic [BYTE_W-1:0] chk;
    chk = SYNC_BYTE ^ 8'h11 ^ 8'h22 ^ 8'h33 ^ 8'h44 ^ 8'h55 ^ 8'h66;
    write_timeout(IDLE_MAX);
    rx_gaps     = 1'b0;
    sink_stalls = 1'b0;
    send_item(OP_BYTE, SYNC_BYTE);
    send_item(OP_BYTE, 8'h11);
    send_item(OP_BYTE, 8'h22);
    send_item(OP_BYTE, 8'h33);
    repeat (TICK_RUN) send_item(OP_TICK, 8'h00);
    send_item(OP_BYTE, 8'h44);
    send_item(OP_BYTE, 8'h55);
    send_item(OP_BYTE, 8'h66);
    send_item(OP_BYTE, chk);
    rx_gaps     = 1'b1;
    sink_stalls = 1'b1;
  endtask

  // mostly well-formed frames, with noise, tick bursts and abandoned frames
  task automatic test_random_traffic(input logic [MS_W-1:0] timeout_ms, input int quota,
                                     input bit idling, input bit hold_midway);
    frame_body_t       body;
    int                sent;
    int                pick;
    int                n;
    bit                held;
    logic [BYTE_W-1:0] b;
    write_timeout(timeout_ms);
    rx_gaps     = idling;
    sink_stalls = idling;
    sent        = 0;
    held        = 1'b0;
    while (sent < quota) begin
      if (hold_midway && !held && sent >= quota / 2) begin
        wait_frames_drained();
        held = 1'b1;
      end
      pick = $urandom_range(0, 99);
      foreach (body[k]) body[k] = 8'($urandom_range(0, 255));
      if (pick < 60) begin
        send_frame(body, 8'h00, bit'(pick < 20), sent);
      end else if (pick < 70) begin
        send_frame(body, 8'($urandom_range(1, 255)), 1'b0, sent);
      end else if (pick < 78) begin
        n = $urandom_range(1, 3);
        repeat (n) begin
          b = 8'($urandom_range(0, 255));
          if (b == SYNC_BYTE)
            b = ~b;
          send_item(OP_BYTE, b);
        end
        sent += n;
      end else if (pick < 88) begin
        n = $urandom_range(1, 4);
        repeat (n) send_item(OP_TICK, 8'($urandom_range(0, 255)));
        sent += n;
      end else begin
        n = $urandom_range(0, 5);
        send_item(OP_BYTE, SYNC_BYTE);
        sent++;
        repeat (n) begin
          send_item(OP_BYTE, 8'($urandom_range(0, 255)));
          sent++;
        end
        n = (timeout_ms < 40) ? int'(timeout_ms) + 1 : $urandom_range(1, 5);
        repeat (n) send_item(OP_TICK, 8'($urandom_range(0, 255)));
        sent += n;
      end
    end
    rx_gaps     = 1'b1;
    sink_stalls = 1'b1;
  endtask

  initial begin
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    rx_if.valid   = 1'b0;
    rx_if.opcode  = OP_BYTE;
    rx_if.rx_byte = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_sync_and_checksum();
    test_timeout_limits();
    test_idle_saturation();
    test_random_traffic(16'd1, 80, 1'b1, 1'b1);
    test_random_traffic(16'($urandom_range(2, 30)), 100, 1'b1, 1'b0);
    test_random_traffic(IDLE_MAX, 50, 1'b0, 1'b0);
    test_random_traffic(TIMEOUT_RESET, 80, 1'b1, 1'b0);

    // drain and let the block settle
    wait_frames_drained();
    repeat (TAIL_CYC) @(negedge clk);
    if (mismatch_count == 0 && frame_bytes_due.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/sfrx_pkg.sv
rtl/core/sfrx_if.sv
rtl/core/sfrx_ram.sv
rtl/core/sfrx_ctrl.sv
rtl/core/sfrx_dp.sv
rtl/core/sync_frame_receiver_xor_check.sv
dv/sync_frame_receiver_xor_check_tb.sv
